// ===== hdl/rcpa_pkg.sv =====
// Shared types and constants for the reference-counted pool allocator.
// No dependencies; imported by rcpa_front, rcpa_back and the top level.
package rcpa_pkg;

    // Default sizing of the pool
    localparam int DEF_POOL_ENTRIES = 64;
    localparam int DEF_COUNT_BITS   = 16;

    // Fixed payload widths
    localparam int ACTION_W    = 2;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 16;

    // Action codes on the input channel
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP  = 2'd2;

    // Status codes on the result channel
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_AT_MAX    = 2'd3;

    // Decoded operation
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_ADD,
        OP_DROP,
        OP_NOP
    } t_op;

    // Classified request, front to back
    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic              in_range;
    } t_req;

endpackage

// ===== hdl/rcpa_front.sv =====
// Front end: accepts input items, decodes and range-checks them, and
// buffers them in a two-entry queue for the back end. Uses rcpa_pkg.
module rcpa_front
    import rcpa_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_init_done,
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output t_req                o_q_req
);

    t_req       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;
    t_req       w_req;
    logic       w_push;
    logic       w_pop;

    // Decode the action and check the slot against the pool size
    always_comb begin
        case (i_action)
            ACT_ALLOC: w_req.op = OP_ALLOC;
            ACT_ADD:   w_req.op = OP_ADD;
            ACT_DROP:  w_req.op = OP_DROP;
            default:   w_req.op = OP_NOP;
        endcase
        w_req.slot     = i_slot;
        w_req.in_range = (32'(i_slot) < POOL_ENTRIES);
    end

    // No items taken while the back end clears its memories
    assign o_in_ready = (r_fill != 2'd2) && i_init_done;
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_fill != 2'd0);
    assign w_pop      = o_q_valid && i_q_ready;
    assign o_q_req    = r_mem[r_rptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_req;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== hdl/rcpa_back.sv =====
// Back end: reference count memory, free-slot stack memory, the execute
// sequencer and the result register. Uses rcpa_pkg.
module rcpa_back
    import rcpa_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_ready,
    input  t_req                   i_q_req,
    output logic                   o_init_done,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [SLOT_W-1:0]      o_granted_slot,
    output logic [OUT_COUNT_W-1:0] o_new_count,
    output logic                   o_released
);

    localparam int IDX_W   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int DEPTH_W = $clog2(POOL_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // Memories
    logic [COUNT_BITS-1:0] r_cnt_mem [POOL_ENTRIES];
    logic [IDX_W-1:0]      r_stk_mem [POOL_ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [IDX_W-1:0]      r_stk_rd;

    // Control and result registers
    t_state                r_state;
    logic [IDX_W-1:0]      r_clr;
    logic [DEPTH_W-1:0]    r_depth;
    t_req                  r_req;
    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [SLOT_W-1:0]     r_gslot;
    logic [OUT_COUNT_W-1:0] r_ncount;
    logic                  r_released;

    // Execute results
    logic                  w_fire;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [STATUS_W-1:0]   e_status;
    logic [SLOT_W-1:0]     e_gslot;
    logic [COUNT_BITS-1:0] e_ncount;
    logic                  e_released;
    logic                  e_cnt_we;
    logic [IDX_W-1:0]      e_cnt_wa;
    logic [COUNT_BITS-1:0] e_cnt_wd;
    logic                  e_push;
    logic                  e_pop;
    logic [DEPTH_W-1:0]    n_depth;

    // Memory write ports
    logic                  w_cnt_we;
    logic [IDX_W-1:0]      w_cnt_wa;
    logic [COUNT_BITS-1:0] w_cnt_wd;
    logic                  w_stk_we;
    logic [IDX_W-1:0]      w_stk_wa;
    logic [IDX_W-1:0]      w_stk_wd;

    assign o_q_ready   = (r_state == S_IDLE);
    assign o_init_done = (r_state != S_CLEAR);
    assign w_fire      = (r_state == S_EXEC) && (!r_o_valid || i_out_ready);
    assign w_cnt       = r_req.in_range ? r_cnt_rd : '0;

    // Execute one operation on the registered memory reads
    always_comb begin
        e_status   = ST_OK;
        e_gslot    = r_req.slot;
        e_ncount   = '0;
        e_released = 1'b0;
        e_cnt_we   = 1'b0;
        e_cnt_wa   = IDX_W'(r_req.slot);
        e_cnt_wd   = '0;
        e_push     = 1'b0;
        e_pop      = 1'b0;
        case (r_req.op)
            OP_ALLOC: begin
                if (r_depth == '0) begin
                    e_status = ST_EMPTY;
                    e_gslot  = '0;
                end else begin
                    e_pop    = 1'b1;
                    e_gslot  = SLOT_W'(r_stk_rd);
                    e_ncount = COUNT_BITS'(1);
                    e_cnt_we = 1'b1;
                    e_cnt_wa = r_stk_rd;
                    e_cnt_wd = COUNT_BITS'(1);
                end
            end
            OP_ADD: begin
                if (w_cnt == '0) begin
                    e_status = ST_NOT_ALLOC;
                end else if (&w_cnt) begin
                    e_status = ST_AT_MAX;
                    e_ncount = w_cnt;
                end else begin
                    e_ncount = w_cnt + COUNT_BITS'(1);
                    e_cnt_we = 1'b1;
                    e_cnt_wd = w_cnt + COUNT_BITS'(1);
                end
            end
            OP_DROP: begin
                if (w_cnt == '0) begin
                    e_status = ST_NOT_ALLOC;
                end else begin
                    // count of one: slot goes back on the free stack if it is not full
                    e_ncount   = w_cnt - COUNT_BITS'(1);
                    e_cnt_we   = 1'b1;
                    e_cnt_wd   = w_cnt - COUNT_BITS'(1);
                    e_released = (w_cnt == COUNT_BITS'(1));
                    e_push     = e_released && (r_depth < DEPTH_W'(POOL_ENTRIES));
                end
            end
            default: begin
                e_ncount = w_cnt;
            end
        endcase
    end

    // Stack depth update; the stack is full once the clearing pass ends
    always_comb begin
        n_depth = r_depth;
        if (r_state == S_CLEAR && r_clr == IDX_W'(POOL_ENTRIES - 1)) begin
            n_depth = DEPTH_W'(POOL_ENTRIES);
        end else if (w_fire && e_pop) begin
            n_depth = r_depth - DEPTH_W'(1);
        end else if (w_fire && e_push) begin
            n_depth = r_depth + DEPTH_W'(1);
        end
    end

    // Write port muxing: clearing pass or execute
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_cnt_we = 1'b1;
            w_cnt_wa = r_clr;
            w_cnt_wd = '0;
            w_stk_we = 1'b1;
            w_stk_wa = r_clr;
            w_stk_wd = r_clr;
        end else begin
            w_cnt_we = w_fire && e_cnt_we;
            w_cnt_wa = e_cnt_wa;
            w_cnt_wd = e_cnt_wd;
            w_stk_we = w_fire && e_push;
            w_stk_wa = IDX_W'(r_depth);
            w_stk_wd = IDX_W'(r_req.slot);
        end
    end

    // Count memory, read at the queue head when the back end takes an item
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_cnt_wa] <= w_cnt_wd;
        end
        if (r_state == S_IDLE) begin
            r_cnt_rd <= r_cnt_mem[IDX_W'(i_q_req.slot)];
        end
    end

    // Free stack memory, read at the top of stack
    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_wa] <= w_stk_wd;
        end
        r_stk_rd <= r_stk_mem[IDX_W'(r_depth - DEPTH_W'(1))];
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            if (w_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(POOL_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_IDLE && i_q_valid) begin
                r_req <= i_q_req;
            end
            if (w_fire) begin
                r_status   <= e_status;
                r_gslot    <= e_gslot;
                r_ncount   <= OUT_COUNT_W'(e_ncount);
                r_released <= e_released;
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_gslot;
    assign o_new_count    = r_ncount;
    assign o_released     = r_released;

endmodule

// ===== hdl/ref_counted_pool_allocator_top.sv =====
// Top level of the reference-counted pool allocator.
// Instantiates rcpa_front and rcpa_back; uses rcpa_pkg.
//
// Pool of POOL_ENTRIES slots with a COUNT_BITS-bit reference count each and
// a last-in-first-out free stack; after reset the highest index is handed
// out first. Each item (allocate, add reference, drop reference) gives one
// result item. After reset the block runs a clearing pass over every entry
// of the count and stack memories and takes no item until it is done.
// The front end decodes items into a two-entry queue; the back end
// handles each item with a registered read of the count and free-stack
// memories in S_IDLE, then executes and writes back in S_EXEC, and takes
// the next item only once back in S_IDLE. The result register lets the
// next item be taken while a result waits on o_out_valid.
module ref_counted_pool_allocator_top
    import rcpa_pkg::*;
#(
    parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [ACTION_W-1:0]    i_action,
    input  logic [SLOT_W-1:0]      i_slot,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATUS_W-1:0]    o_status,
    output logic [SLOT_W-1:0]      o_granted_slot,
    output logic [OUT_COUNT_W-1:0] o_new_count,
    output logic                   o_released
);

    logic w_q_valid;
    logic w_q_ready;
    t_req w_q_req;
    logic w_init_done;

    // Decode and queue
    rcpa_front #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_slot      (i_slot),
        .i_init_done (w_init_done),
        .o_q_valid   (w_q_valid),
        .i_q_ready   (w_q_ready),
        .o_q_req     (w_q_req)
    );

    // Memories and execute
    rcpa_back #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_q_ready      (w_q_ready),
        .i_q_req        (w_q_req),
        .o_init_done    (w_init_done),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_new_count    (o_new_count),
        .o_released     (o_released)
    );

endmodule
